// ===== sv/ssbo_pkg.sv =====
// Shared constants, types and coefficient tables for the balance observer.
package ssbo_pkg;

    localparam int NUM_OPS   = 52;
    localparam int OP_W      = 6;
    localparam int EST_W     = 56;
    localparam int NX_W      = 48;
    localparam int STATE_W   = 40;
    localparam int OUT_W     = 24;
    localparam int THETA_W   = 30;
    localparam int PSI_W     = 24;
    localparam int DRIVE_W   = 32;
    localparam longint DecScale = 64'sd1000000000;

    // operand sources
    localparam logic [3:0] SRC_X0    = 4'd0;
    localparam logic [3:0] SRC_X1    = 4'd1;
    localparam logic [3:0] SRC_THETA = 4'd4;
    localparam logic [3:0] SRC_PSI   = 4'd5;
    localparam logic [3:0] SRC_DRIVE = 4'd6;
    localparam logic [3:0] SRC_EST0  = 4'd8;
    // accumulator targets
    localparam logic [3:0] DST_EST0  = 4'd0;
    localparam logic [3:0] DST_ACC   = 4'd4;
    localparam logic [3:0] DST_NX0   = 4'd8;

    typedef struct packed {
        logic [3:0] src;
        logic [3:0] dst;
    } t_op;

    typedef longint t_qtab [NUM_OPS];

    localparam longint MAT_A [4][4] = '{
        '{ 623066480,  859213570,   4418650,   5537130},
        '{  86791390,  558895840,   1940590,   8088540},
        '{-560029300, -451738570, 270365660, 719473060},
        '{  58722390, -570395780, 254101880, 753561520}
    };
    localparam longint MAT_B [4][4] = '{
        '{   5424800,    5424800,  376933520, -869374860},
        '{  -1886160,   -1886160,  -86791390,  448767570},
        '{ 709169110,  709169110,  560029300, -666090730},
        '{-246974680, -246974680,  -58722390, 1786538310}
    };
    localparam longint MAT_C [4][2] = '{
        '{   665202880,   738666180},
        '{    73866620,   610371870},
        '{-64'sd16130453270, 64'sd53456379640},
        '{ 64'sd5397925030, -64'sd19767545520}
    };
    localparam longint MAT_D [4][2] = '{
        '{  334797120,   -738666180},
        '{  -73866620,    389628130},
        '{ 64'sd16130453270, -64'sd53456379640},
        '{-64'sd5397925030,   64'sd19767545520}
    };
    localparam longint GAIN_L [4] = '{-560, -64'sd32238743130, -300416427,
                                      -64'sd2963063340};

    // round to nearest, ties away from zero
    function automatic longint quant_coef(longint c9, int f);
        longint mag;
        longint q;
        mag = (c9 < 0) ? -c9 : c9;
        q   = (mag * (64'sd1 << f) + DecScale / 2) / DecScale;
        return (c9 < 0) ? -q : q;
    endfunction

    function automatic t_op op_decode(logic [OP_W-1:0] i);
        t_op        o;
        logic [OP_W-1:0] j;
        j = i - OP_W'(20);
        if (i < OP_W'(16)) begin
            o.dst = DST_EST0 | {2'b00, i[3:2]};
            case (i[1:0])
                2'd0:    o.src = SRC_X0;
                2'd1:    o.src = SRC_X1;
                2'd2:    o.src = SRC_THETA;
                default: o.src = SRC_PSI;
            endcase
        end else if (i < OP_W'(20)) begin
            o.src = SRC_EST0 | {2'b00, i[1:0]};
            o.dst = DST_ACC;
        end else begin
            o.dst = DST_NX0 | {2'b00, j[4:3]};
            if (!j[0]) begin
                o.src = SRC_X0 | {2'b00, j[2:1]};
            end else begin
                case (j[2:1])
                    2'd2:    o.src = SRC_THETA;
                    2'd3:    o.src = SRC_PSI;
                    default: o.src = SRC_DRIVE;
                endcase
            end
        end
        return o;
    endfunction

    function automatic longint coef_c9(int i);
        int j;
        j = i - 20;
        if (i < 16)
            return ((i & 3) < 2) ? MAT_C[i >> 2][i & 1] : MAT_D[i >> 2][i & 1];
        else if (i < 20)
            return GAIN_L[i - 16];
        else if ((j & 1) == 0)
            return MAT_A[j >> 3][(j >> 1) & 3];
        else
            return MAT_B[j >> 3][(j >> 1) & 3];
    endfunction

    function automatic t_qtab quant_tab(int f);
        t_qtab t;
        for (int i = 0; i < NUM_OPS; i++) begin
            t[i] = quant_coef(coef_c9(i), f);
        end
        return t;
    endfunction

endpackage

// ===== sv/state_space_balance_observer_top.sv =====
// Balance observer: operation sequencer, state registers and output stage.
// Each input item runs 52 multiply operations in turn on the single digit-serial multiplier
// (ND = (COEF_FRAC_BITS+11)/4 coefficient digits each), then an output step.
// A new item is accepted only once the previous result has been loaded into the output
// register; a stalled result holds the last step until the output register frees.
// Synchronous active-low reset clears the observer state and all handshakes.
module state_space_balance_observer_top #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_body_angle,
    input  logic [21:0] i_wheel_angle,
    input  logic [15:0] i_motor_drive,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_drive_command
);
    import ssbo_pkg::*;

    localparam int ND = (8 + COEF_FRAC_BITS + 3) / 4;
    localparam int PW = 4 * ND;
    localparam t_qtab QTAB = quant_tab(COEF_FRAC_BITS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]                 r_state;
    logic [OP_W-1:0]            r_op;
    logic signed [STATE_W-1:0]  r_x   [4];
    logic signed [EST_W-1:0]    r_est [4];
    logic signed [NX_W-1:0]     r_nx  [4];
    logic signed [EST_W-1:0]    r_acc;
    logic signed [THETA_W-1:0]  r_theta;
    logic signed [PSI_W-1:0]    r_psi;
    logic signed [DRIVE_W-1:0]  r_drive;
    logic [OUT_W-1:0]           r_out;
    logic                       r_out_vld;

    t_op                        w_op;
    longint                     w_coef_full;
    logic signed [EST_W-1:0]    w_value;
    logic                       w_done;
    logic signed [EST_W-1:0]    w_res;
    logic                       w_accept;
    logic                       w_load;
    logic signed [EST_W-1:0]    w_neg;
    logic signed [EST_W-9:0]    w_scaled;
    logic [OUT_W-1:0]           w_out_sat;
    logic signed [STATE_W-1:0]  w_x_sat [4];

    assign w_op        = op_decode(r_op);
    assign w_coef_full = QTAB[r_op];
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load      = (r_state == S_FIN) && (!r_out_vld || !i_out_stall);

    always_comb begin
        case (w_op.src)
            SRC_THETA: w_value = EST_W'(r_theta);
            SRC_PSI:   w_value = EST_W'(r_psi);
            SRC_DRIVE: w_value = EST_W'(r_drive);
            default: begin
                if (w_op.src[3]) begin
                    w_value = r_est[w_op.src[1:0]];
                end else begin
                    w_value = EST_W'(r_x[w_op.src[1:0]]);
                end
            end
        endcase
    end

    ssbo_mac #(
        .VW(EST_W),
        .FB(COEF_FRAC_BITS),
        .ND(ND),
        .RW(EST_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_ISSUE),
        .i_value  (w_value),
        .i_coef   (w_coef_full[PW-1:0]),
        .o_done   (w_done),
        .o_result (w_res)
    );

    // negate, round to Q16.8, clamp
    assign w_neg    = -r_acc + EST_W'(128);
    assign w_scaled = w_neg[EST_W-1:8];
    always_comb begin
        if (w_scaled[EST_W-9:OUT_W-1] == '0 || w_scaled[EST_W-9:OUT_W-1] == '1) begin
            w_out_sat = w_scaled[OUT_W-1:0];
        end else begin
            w_out_sat = w_scaled[EST_W-9] ? {1'b1, {(OUT_W-1){1'b0}}}
                                          : {1'b0, {(OUT_W-1){1'b1}}};
        end
        for (int r = 0; r < 4; r++) begin
            if (r_nx[r][NX_W-1:STATE_W-1] == '0 || r_nx[r][NX_W-1:STATE_W-1] == '1) begin
                w_x_sat[r] = r_nx[r][STATE_W-1:0];
            end else begin
                w_x_sat[r] = r_nx[r][NX_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                             : {1'b0, {(STATE_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= '0;
            r_out_vld <= 1'b0;
            for (int r = 0; r < 4; r++) begin
                r_x[r] <= '0;
            end
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_op    <= (r_op == OP_W'(NUM_OPS - 1)) ? '0 : r_op + OP_W'(1);
                        r_state <= (r_op == OP_W'(NUM_OPS - 1)) ? S_FIN : S_ISSUE;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        for (int r = 0; r < 4; r++) begin
                            r_x[r] <= w_x_sat[r];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_psi   <= PSI_W'(signed'(i_body_angle)) <<< 8;
            r_theta <= THETA_W'(signed'(i_wheel_angle)) <<< 8;
            r_drive <= DRIVE_W'(signed'(i_motor_drive)) <<< 16;
            r_acc   <= '0;
            r_est[0] <= '0;
            r_est[1] <= '0;
            r_est[2] <= EST_W'(r_x[2]);
            r_est[3] <= EST_W'(r_x[3]);
            for (int r = 0; r < 4; r++) begin
                r_nx[r] <= '0;
            end
        end else if (r_state == S_WAIT && w_done) begin
            if (w_op.dst[3]) begin
                r_nx[w_op.dst[1:0]] <= r_nx[w_op.dst[1:0]] + NX_W'(w_res);
            end else if (w_op.dst == DST_ACC) begin
                r_acc <= r_acc + w_res;
            end else begin
                r_est[w_op.dst[1:0]] <= r_est[w_op.dst[1:0]] + w_res;
            end
        end
        if (w_load) begin
            r_out <= w_out_sat;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_drive_command = r_out;

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_op < OP_W'(NUM_OPS))
        else $error("operation index out of range");
    a_fin_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT && w_done && r_op == OP_W'(NUM_OPS - 1) |=> r_state == S_FIN)
        else $error("sequence did not finish after last operation");

endmodule

// ===== sv/ssbo_mac.sv =====
// Digit-serial signed multiplier, four coefficient bits per cycle, with rounding.
module ssbo_mac #(
    parameter int VW = 56,
    parameter int FB = 16,
    parameter int ND = 6,
    parameter int RW = 56
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [VW-1:0] i_value,
    input  logic [4*ND-1:0]      i_coef,
    output logic                 o_done,
    output logic signed [RW-1:0] o_result
);
    localparam int PW  = 4 * ND;
    localparam int PRW = VW + PW;
    localparam int CW  = $clog2(ND);
    localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (FB - 1);

    logic signed [VW-1:0]  r_value;
    logic [PW-1:0]         r_coef;
    logic signed [PRW-1:0] r_prod;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_first;
    logic                  r_rnd;
    logic                  r_done;
    logic signed [RW-1:0]  r_result;

    logic [3:0]            w_dig;
    logic signed [4:0]     w_dig_s;
    logic signed [VW+4:0]  w_pp;
    logic signed [PRW-1:0] w_sum;

    assign w_dig   = r_coef[PW-1 -: 4];
    // top digit carries the sign, the rest are unsigned
    assign w_dig_s = r_first ? signed'({w_dig[3], w_dig}) : signed'({1'b0, w_dig});
    assign w_pp    = r_value * w_dig_s;
    assign w_sum   = r_prod + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_rnd  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_rnd  <= 1'b1;
            end
            if (r_rnd) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_value <= i_value;
            r_coef  <= i_coef;
            r_prod  <= '0;
            r_cnt   <= CW'(ND - 1);
            r_first <= 1'b1;
        end else if (r_busy) begin
            r_prod  <= (r_prod <<< 4) + PRW'(w_pp);
            r_coef  <= r_coef << 4;
            r_cnt   <= r_cnt - CW'(1);
            r_first <= 1'b0;
        end
        if (r_rnd) begin
            r_result <= RW'(w_sum >>> FB);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_rnd)
        else $error("multiply started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held for more than one cycle");

endmodule

// ===== sim/state_space_balance_observer_top_tb.sv =====
// Self-checking testbench for the balance observer: directed and random ticks, predicted drive.
module state_space_balance_observer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssbo_pkg::*;

    typedef struct {
        logic [15:0] body;
        logic [21:0] wheel;
        logic [15:0] drive;
    } t_tick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_body_angle = '0;
    logic [21:0] i_wheel_angle = '0;
    logic [15:0] i_motor_drive = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [23:0] o_drive_command;

    state_space_balance_observer_top uut (.*);

    t_tick       pending_ticks[$];
    logic [23:0] expected_drive[$];
    int          mismatches = 0;
    int          in_gap = 0;
    int          out_gap = 0;

    // observer copy and quantized coefficients
    longint obs_x[4];
    longint qa[4][4], qb[4][4], qc[4][2], qd[4][2], ql[4];

    function automatic longint to_q16(longint c9);
        longint mag;
        longint q;
        mag = (c9 < 0) ? -c9 : c9;
        q = (mag * 65536 + 500000000) / 1000000000;
        return (c9 < 0) ? -q : q;
    endfunction

    function automatic longint scale_mul(longint v, longint c);
        longint hi;
        longint lo;
        hi = v >>> 16;
        lo = v - (hi <<< 16);
        return hi * c + ((lo * c + 32768) >>> 16);
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic logic [23:0] observe_tick(t_tick t);
        longint psi, theta, drv, acc, s;
        longint u[4], est[4], nx[4];
        psi   = longint'($signed(t.body)) * 256;
        theta = longint'($signed(t.wheel)) * 256;
        drv   = longint'($signed(t.drive)) * 65536;
        u[0] = drv; u[1] = drv; u[2] = theta; u[3] = psi;
        acc = 0;
        for (int r = 0; r < 4; r++) begin
            est[r] = scale_mul(obs_x[0], qc[r][0]) + scale_mul(obs_x[1], qc[r][1])
                   + scale_mul(theta, qd[r][0]) + scale_mul(psi, qd[r][1]);
            if (r >= 2) est[r] += obs_x[r];
            acc += scale_mul(est[r], ql[r]);
        end
        acc = clamp((-acc + 128) >>> 8, 24);
        for (int r = 0; r < 4; r++) begin
            s = 0;
            for (int k = 0; k < 4; k++)
                s += scale_mul(obs_x[k], qa[r][k]) + scale_mul(u[k], qb[r][k]);
            nx[r] = clamp(s, 40);
        end
        for (int r = 0; r < 4; r++) obs_x[r] = nx[r];
        return acc[23:0];
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(50, 300);
        return $urandom_range(0, 6);
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        logic nv;
        t_tick t;
        if (i_rst_n) begin
            nv = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                t.body = i_body_angle; t.wheel = i_wheel_angle; t.drive = i_motor_drive;
                expected_drive.push_back(observe_tick(t));
                nv = 1'b0;
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                end else if (pending_ticks.size() > 0) begin
                    t = pending_ticks.pop_front();
                    i_body_angle  <= t.body;
                    i_wheel_angle <= t.wheel;
                    i_motor_drive <= t.drive;
                    nv = 1'b1;
                    in_gap <= pick_gap();
                end
            end
            i_in_valid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_drive.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected drive_command %h", o_drive_command);
                end else begin
                    want = expected_drive.pop_front();
                    if (want !== o_drive_command) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive_command mismatch: expected %h actual %h",
                                     want, o_drive_command);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                out_gap <= pick_gap();
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_tick mk(int b, int w, int d);
        t_tick t;
        t.body = b[15:0]; t.wheel = w[21:0]; t.drive = d[15:0];
        return t;
    endfunction

    initial begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                qa[r][k] = to_q16(MAT_A[r][k]);
                qb[r][k] = to_q16(MAT_B[r][k]);
            end
            for (int k = 0; k < 2; k++) begin
                qc[r][k] = to_q16(MAT_C[r][k]);
                qd[r][k] = to_q16(MAT_D[r][k]);
            end
            ql[r] = to_q16(GAIN_L[r]);
            obs_x[r] = 0;
        end
        // directed: zero, field extremes, out-of-range patterns
        pending_ticks.push_back(mk(0, 0, 0));
        pending_ticks.push_back(mk(32767, 0, 0));
        pending_ticks.push_back(mk(-32768, 0, 0));
        pending_ticks.push_back(mk(0, 2048000, 0));
        pending_ticks.push_back(mk(0, -2048000, 0));
        pending_ticks.push_back(mk(0, 2097151, 0));
        pending_ticks.push_back(mk(0, -2097152, 0));
        pending_ticks.push_back(mk(0, 0, 32767));
        pending_ticks.push_back(mk(0, 0, -32768));
        pending_ticks.push_back(mk(1, -1, 1));
        // drive state and output into saturation
        for (int i = 0; i < 6; i++) pending_ticks.push_back(mk(32767, 2097151, 32767));
        for (int i = 0; i < 6; i++) pending_ticks.push_back(mk(-32768, -2097152, -32768));
        pending_ticks.push_back(mk(0, 0, 0));
        pending_ticks.push_back(mk(-1, -1, -1));
        for (int i = 0; i < 850; i++) begin
            case ($urandom_range(0, 3))
                0: pending_ticks.push_back(mk($urandom, $urandom, $urandom));
                1: pending_ticks.push_back(mk($urandom_range(0, 1023) - 512,
                       $urandom_range(0, 40000) - 20000, $urandom_range(0, 255) - 128));
                default: pending_ticks.push_back(mk($urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 4096000) - 2048000, $urandom_range(0, 65535) - 32768));
            endcase
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_ticks.size() == 0 && !i_in_valid && expected_drive.size() == 0);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && expected_drive.size() == 0) begin
            $display("state_space_balance_observer_top_tb: PASS");
        end else begin
            $display("state_space_balance_observer_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("state_space_balance_observer_top_tb: FAIL");
        $finish;
    end
endmodule
